@@ rtl/zcpf_pkg.sv @@
// Shared types and constants of the zero-crossing period and frequency unit.
`default_nettype none

package zcpf_pkg;

    // Sample and block limits
    localparam int SAMPLE_W        = 16;
    localparam int INDEX_W         = 16;
    localparam int TIME_W          = 32;
    localparam int COUNT_W         = 16;
    localparam int CAP_W           = 8;
    localparam int RATE_W          = 28;
    localparam int MAX_STORED_CROSSINGS = 128;

    // Result field widths
    localparam int STATUS_W        = 2;
    localparam int PER_W           = 32;
    localparam int NS_W            = 54;
    localparam int FREQ_W          = 44;
    localparam int RESULT_W        = STATUS_W + COUNT_W + PER_W + NS_W + FREQ_W;
    localparam int OUT_TDATA_W     = ((RESULT_W + 7) / 8) * 8;

    // Serial divider sizing
    localparam int DIV_NUM_W       = 68;
    localparam int DIV_DEN_W       = 52;
    localparam int DIV_CNT_W       = 7;

    localparam logic [DIV_CNT_W-1:0] FRAC_STEPS = DIV_CNT_W'(16);
    localparam logic [DIV_CNT_W-1:0] PER_STEPS  = DIV_CNT_W'(32);
    localparam logic [DIV_CNT_W-1:0] NS_STEPS   = DIV_CNT_W'(62);
    localparam logic [DIV_CNT_W-1:0] FREQ_STEPS = DIV_CNT_W'(68);

    localparam logic [29:0]       NS_PER_S   = 30'd1_000_000_000;
    localparam logic [NS_W-1:0]   NS_MAX     = '1;
    localparam logic [FREQ_W-1:0] FREQ_MAX   = '1;
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

    // Request queue between front and back
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_AW        = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FEW   = 2'd1,
        STATUS_RATE0 = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_FRAC,
        BS_DIFF,
        BS_MUL,
        BS_PER,
        BS_NS,
        BS_FREQ,
        BS_OUT
    } t_bstate;

    // One request from the front: a crossing, a block end, or both
    typedef struct packed {
        logic                 crossing;
        logic                 last;
        logic [SAMPLE_W-1:0]  neg;
        logic [SAMPLE_W-1:0]  den;
        logic [INDEX_W-1:0]   base;
    } t_entry;

    typedef struct packed {
        logic                  start;
        logic [DIV_DEN_W-1:0]  rem_init;
        logic [DIV_NUM_W-1:0]  num;
        logic [DIV_DEN_W-1:0]  den;
        logic [DIV_CNT_W-1:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIV_NUM_W-1:0]  quo;
    } t_div_rsp;

    typedef struct packed {
        logic [FREQ_W-1:0]   freq;
        logic [NS_W-1:0]     ns;
        logic [PER_W-1:0]    per;
        logic [COUNT_W-1:0]  count;
        t_status             status;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/zcpf_front.sv @@
// Front end: takes samples, finds rising crossings and queues requests for the back end.
`default_nettype none

module zcpf_front
    import zcpf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [SAMPLE_W-1:0]  i_sample,
    input  wire logic                 i_block_end,
    input  wire logic                 i_q_full,
    output logic                      o_q_push,
    output t_entry                    o_q_entry
);

    logic [SAMPLE_W-1:0] r_prev;
    logic                r_have;
    logic [INDEX_W-1:0]  r_index;

    logic                w_accept;
    logic                w_prev_nonpos;
    logic                w_cur_pos;
    logic                w_crossing;
    logic [SAMPLE_W:0]   w_den_wide;

    assign o_s_tready = !i_q_full;
    assign w_accept   = i_s_tvalid && !i_q_full;

    // Classify: previous at or below zero, current above zero
    assign w_prev_nonpos = r_prev[SAMPLE_W-1] || (r_prev == '0);
    assign w_cur_pos     = !i_sample[SAMPLE_W-1] && (i_sample != '0);
    assign w_crossing    = r_have && w_prev_nonpos && w_cur_pos;
    assign w_den_wide    = {i_sample[SAMPLE_W-1], i_sample} - {r_prev[SAMPLE_W-1], r_prev};

    // Build the request; only crossings and block ends are queued
    always_comb begin
        o_q_entry.crossing = w_crossing;
        o_q_entry.last     = i_block_end;
        o_q_entry.neg      = ~r_prev + SAMPLE_W'(1);
        o_q_entry.den      = w_den_wide[SAMPLE_W-1:0];
        o_q_entry.base     = r_index - INDEX_W'(1);
        o_q_push           = w_accept && (w_crossing || i_block_end);
    end

    // Track the previous sample and the index within the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_have  <= 1'b0;
            r_index <= '0;
        end else if (w_accept) begin
            if (i_block_end) begin
                r_prev  <= '0;
                r_have  <= 1'b0;
                r_index <= '0;
            end else begin
                r_prev <= i_sample;
                r_have <= 1'b1;
                if (r_index != '1) begin
                    r_index <= r_index + INDEX_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/zcpf_queue.sv @@
// Short request queue that decouples the front end from the back end.
`default_nettype none

module zcpf_queue
    import zcpf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_entry  i_entry,
    output logic         o_full,
    input  wire logic    i_pop,
    output logic         o_valid,
    output t_entry       o_entry
);

    t_entry                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Store requests
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/zcpf_div.sv @@
// Restoring serial divider, one quotient bit per cycle, shared by all divisions.
`default_nettype none

module zcpf_div
    import zcpf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_div_req  i_req,
    output t_div_rsp       o_rsp
);

    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   w_shifted;
    logic [DIV_DEN_W+1:0] w_trial;
    logic                 w_fits;

    // Shift in the next numerator bit and try the subtraction
    assign w_shifted = {r_rem, r_num[DIV_NUM_W-1]};
    assign w_trial   = {1'b0, w_shifted} - {2'b00, r_den};
    assign w_fits    = !w_trial[DIV_DEN_W+1];

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem_init;
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_trial[DIV_DEN_W-1:0] : w_shifted[DIV_DEN_W-1:0];
            r_num <= {r_num[DIV_NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_fits};
        end
    end

    // Step count and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt  <= i_req.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/zcpf_back.sv @@
// Back end: crossing times, block statistics and the result register.
`default_nettype none

module zcpf_back
    import zcpf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire t_entry             i_q_entry,
    output logic                    o_q_pop,
    input  wire logic [RATE_W-1:0]  i_rate,
    output t_div_req                o_div_req,
    input  wire t_div_rsp           i_div_rsp,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output t_result                 o_result
);

    t_bstate              r_state;
    t_bstate              n_state;

    // Request in flight
    logic                 r_last;
    logic [INDEX_W-1:0]   r_base;

    // Block statistics
    logic [TIME_W-1:0]    r_first;
    logic [TIME_W-1:0]    r_latest;
    logic [COUNT_W-1:0]   r_total;
    logic [TIME_W-1:0]    r_cap_latest;
    logic [CAP_W-1:0]     r_cap_count;

    // Closing arithmetic
    logic [TIME_W-1:0]    r_diff;
    logic [TIME_W-1:0]    r_cdiff;
    logic [COUNT_W-1:0]   r_periods;
    logic [CAP_W-2:0]     r_cap_m1;
    logic [61:0]          r_prod;
    logic [43:0]          r_pf;
    logic [34:0]          r_q;
    t_status              r_status;
    logic [COUNT_W-1:0]   r_count;
    logic [PER_W-1:0]     r_per;
    logic [NS_W-1:0]      r_ns;
    logic [FREQ_W-1:0]    r_freq;

    t_result              r_res;
    logic                 r_ovalid;

    t_status              w_status;
    logic [TIME_W-1:0]    w_time;
    logic                 w_out_free;

    assign w_time     = {r_base, i_div_rsp.quo[15:0]};
    assign w_out_free = !r_ovalid || i_m_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_result   = r_res;

    // Rate zero wins over too few crossings
    always_comb begin
        if (i_rate == '0) begin
            w_status = STATUS_RATE0;
        end else if (r_total < COUNT_W'(2)) begin
            w_status = STATUS_FEW;
        end else begin
            w_status = STATUS_OK;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state, queue pop and divider launches
    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        o_div_req = '0;
        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_entry.crossing) begin
                        o_div_req.start    = 1'b1;
                        o_div_req.rem_init = DIV_DEN_W'(i_q_entry.neg);
                        o_div_req.num      = '0;
                        o_div_req.den      = DIV_DEN_W'(i_q_entry.den);
                        o_div_req.steps    = FRAC_STEPS;
                        n_state            = BS_FRAC;
                    end else begin
                        n_state = BS_DIFF;
                    end
                end
            end
            BS_FRAC: begin
                if (i_div_rsp.done) begin
                    n_state = r_last ? BS_DIFF : BS_IDLE;
                end
            end
            BS_DIFF: begin
                n_state = (w_status == STATUS_OK) ? BS_MUL : BS_OUT;
            end
            BS_MUL: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = {r_diff, (DIV_NUM_W-TIME_W)'(0)};
                o_div_req.den   = DIV_DEN_W'(r_periods);
                o_div_req.steps = PER_STEPS;
                n_state         = BS_PER;
            end
            BS_PER: begin
                if (i_div_rsp.done) begin
                    o_div_req.start = 1'b1;
                    o_div_req.num   = {r_prod, 6'b0};
                    o_div_req.den   = {r_pf, 8'b0};
                    o_div_req.steps = NS_STEPS;
                    n_state         = BS_NS;
                end
            end
            BS_NS: begin
                if (i_div_rsp.done) begin
                    if (r_cdiff == '0) begin
                        n_state = BS_OUT;
                    end else begin
                        o_div_req.start = 1'b1;
                        o_div_req.num   = {1'b0, r_q, 32'b0};
                        o_div_req.den   = DIV_DEN_W'(r_cdiff);
                        o_div_req.steps = FREQ_STEPS;
                        n_state         = BS_FREQ;
                    end
                end
            end
            BS_FREQ: begin
                if (i_div_rsp.done) begin
                    n_state = BS_OUT;
                end
            end
            BS_OUT: begin
                if (w_out_free) begin
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    // Latch the popped request
    always_ff @(posedge i_clk) begin
        if (r_state == BS_IDLE && i_q_valid) begin
            r_last <= i_q_entry.last;
            r_base <= i_q_entry.base;
        end
    end

    // Accumulate crossing times; drop them once the block is closed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first      <= '0;
            r_latest     <= '0;
            r_total      <= '0;
            r_cap_latest <= '0;
            r_cap_count  <= '0;
        end else if (r_state == BS_FRAC && i_div_rsp.done) begin
            if (r_total == '0) begin
                r_first <= w_time;
            end
            r_latest <= w_time;
            if (r_total != '1) begin
                r_total <= r_total + COUNT_W'(1);
            end
            if (r_cap_count < CAP_W'(MAX_STORED_CROSSINGS)) begin
                r_cap_latest <= w_time;
                r_cap_count  <= r_cap_count + CAP_W'(1);
            end
        end else if (r_state == BS_DIFF) begin
            r_first      <= '0;
            r_latest     <= '0;
            r_total      <= '0;
            r_cap_latest <= '0;
            r_cap_count  <= '0;
        end
    end

    // Closing arithmetic, one step per state
    always_ff @(posedge i_clk) begin
        if (r_state == BS_DIFF) begin
            r_diff    <= (r_latest > r_first) ? (r_latest - r_first) : '0;
            r_cdiff   <= (r_cap_latest > r_first) ? (r_cap_latest - r_first) : '0;
            r_periods <= r_total - COUNT_W'(1);
            r_cap_m1  <= r_cap_count[CAP_W-2:0] - (CAP_W-1)'(1);
            r_status  <= w_status;
            r_count   <= r_total;
            r_per     <= '0;
            r_ns      <= '0;
            r_freq    <= '0;
        end
        if (r_state == BS_MUL) begin
            r_prod <= 62'(r_diff) * 62'(NS_PER_S);
            r_pf   <= 44'(r_periods) * 44'(i_rate);
            r_q    <= 35'(i_rate) * 35'(r_cap_m1);
        end
        if (r_state == BS_PER && i_div_rsp.done) begin
            r_per <= i_div_rsp.quo[PER_W-1:0];
        end
        if (r_state == BS_NS && i_div_rsp.done) begin
            r_ns <= (|i_div_rsp.quo[61:NS_W]) ? NS_MAX : i_div_rsp.quo[NS_W-1:0];
            if (r_cdiff == '0) begin
                r_freq <= FREQ_MAX;
            end
        end
        if (r_state == BS_FREQ && i_div_rsp.done) begin
            r_freq <= (|i_div_rsp.quo[DIV_NUM_W-1:FREQ_W]) ? FREQ_MAX
                                                           : i_div_rsp.quo[FREQ_W-1:0];
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == BS_OUT && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BS_OUT && w_out_free) begin
            r_res.status <= r_status;
            r_res.count  <= r_count;
            r_res.per    <= r_per;
            r_res.ns     <= r_ns;
            r_res.freq   <= r_freq;
        end
    end

endmodule

`default_nettype wire

@@ rtl/zero_cross_period_freq_unit.sv @@
// Top level of the zero-crossing period and frequency unit.
//
// Samples stream in on the slave side, the final sample of a block marked by tlast.
// A sample that is neither a rising crossing nor a block end queues no request; a
// rising crossing costs the back end a 16-step serial division that finds its
// fractional time. A four-entry request queue lets the front keep taking samples
// while the back end works. Closing a block takes divisions of 32, 62 and 68 steps on
// the same divider plus set-up; then one result leaves through the master-side register.
// The user must write the sample rate register on the cfg channel only while the unit is
// idle; the block itself does not enforce this. The register resets to 48000 Hz.
`default_nettype none

module zero_cross_period_freq_unit
    import zcpf_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // sample stream
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    input  wire logic [SAMPLE_W-1:0]     i_s_tdata,   // sample[15:0]
    input  wire logic                    i_s_tlast,   // block_end
    // result stream
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    // status[1:0], crossing_count[17:2], period_samples_q16[49:18],
    // period_ns_q8[103:50], frequency_hz_q16[147:104], zero[151:148]
    output logic [OUT_TDATA_W-1:0]       o_m_tdata,
    // sample rate register
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [RATE_W-1:0]       i_cfg_data   // sample_rate_hz
);

    logic [RATE_W-1:0] r_rate;

    logic      w_q_push;
    logic      w_q_full;
    logic      w_q_pop;
    logic      w_q_valid;
    t_entry    w_push_entry;
    t_entry    w_head_entry;
    t_div_req  w_div_req;
    t_div_rsp  w_div_rsp;
    t_result   w_result;

    // Sample rate register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (i_cfg_valid) begin
            r_rate <= i_cfg_data;
        end
    end

    zcpf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_sample    (i_s_tdata),
        .i_block_end (i_s_tlast),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_entry   (w_push_entry)
    );

    zcpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_entry (w_push_entry),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_entry (w_head_entry)
    );

    zcpf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    zcpf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_entry  (w_head_entry),
        .o_q_pop    (w_q_pop),
        .i_rate     (r_rate),
        .o_div_req  (w_div_req),
        .i_div_rsp  (w_div_rsp),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_result   (w_result)
    );

    // Pack the result, first field lowest
    assign o_m_tdata = {(OUT_TDATA_W-RESULT_W)'(0), w_result.freq, w_result.ns,
                        w_result.per, w_result.count, w_result.status};

`ifndef ASSERT_OFF
    // Front pushes only into a queue with room
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("request pushed into a full queue");

    // Divider is launched only while idle
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider launched while busy");

    // An ok result always rests on at least two crossings
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_result.status == STATUS_OK) |-> (w_result.count >= COUNT_W'(2)))
        else $error("ok status with fewer than two crossings");

    // Pop only a waiting request, and only while the divider is idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid && !w_div_rsp.busy)
        else $error("request popped while divider busy or queue empty");
`endif

endmodule

`default_nettype wire

@@ verif/zero_cross_period_freq_unit_tb.sv @@
// Self-checking testbench of the zero-crossing period and frequency unit.
`timescale 1ns / 100ps

module zero_cross_period_freq_unit_tb;
    import zcpf_pkg::*;

    localparam int SETTLE_CYCLES  = 250;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum {ROW_SAMPLE, ROW_RATE} t_row_kind;

    // One stimulus row: a sample (value, last) or a sample rate write (value)
    typedef struct {
        t_row_kind kind;
        int        value;
        bit        last;
        bit        typed;
        t_result   res;
    } t_stim_row;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic [SAMPLE_W-1:0]     s_tdata   = '0;
    logic                    s_tlast   = 1'b0;
    logic                    m_tready  = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic [RATE_W-1:0]       cfg_data  = '0;
    logic                    o_s_tready;
    logic                    o_m_tvalid;
    logic [OUT_TDATA_W-1:0]  o_m_tdata;
    logic                    o_cfg_ready;

    // Block state as the unit should hold it
    bit [RATE_W-1:0]         rate_hz     = RATE_RESET;
    logic signed [15:0]      prev_smp    = '0;
    bit                      have_prev   = 1'b0;
    bit [31:0]               smp_index   = '0;
    bit [31:0]               first_time  = '0;
    bit [31:0]               latest_time = '0;
    bit [31:0]               n_cross     = '0;
    bit [31:0]               cap_time    = '0;
    bit [31:0]               n_cap       = '0;

    t_result                 results_due[$];
    t_stim_row               stim_rows[$];
    int                      mismatches  = 0;
    int                      results_seen = 0;
    int                      burst_left  = 0;
    int                      ready_run   = 0;
    int                      idle_cycles = 0;

    zero_cross_period_freq_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),    // sample[15:0]
        .i_s_tlast   (s_tlast),    // block_end
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        // status[1:0], crossing_count[17:2], period_samples_q16[49:18],
        // period_ns_q8[103:50], frequency_hz_q16[147:104], zero[151:148]
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)    // sample_rate_hz
    );

    always #1 clk = ~clk;

    // Fold one sample into the block; return 1 with the block's result on its last sample
    function automatic bit fold_sample(input logic signed [15:0] smp, input bit last,
                                       output t_result res);
        int        prev_i;
        int        cur_i;
        bit [63:0] num;
        bit [63:0] den;
        bit [31:0] t;
        bit [63:0] diff;
        bit [63:0] periods;
        bit [63:0] ns;
        bit [63:0] cdiff;
        bit [63:0] q;
        bit [63:0] hi;
        bit [63:0] rem;
        bit [63:0] freq;
        res    = '0;
        prev_i = prev_smp;
        cur_i  = smp;
        // rising crossing: place it between the two samples by linear interpolation
        if (have_prev && prev_i <= 0 && cur_i > 0) begin
            num = 64'(-prev_i) << 16;
            den = 64'(cur_i - prev_i);
            t   = ((smp_index - 32'd1) << 16) + 32'(num / den);
            if (n_cross == 0)
                first_time = t;
            latest_time = t;
            if (n_cross < 65535)
                n_cross++;
            if (n_cap < MAX_STORED_CROSSINGS) begin
                cap_time = t;
                n_cap++;
            end
        end
        prev_smp  = smp;
        have_prev = 1'b1;
        if (smp_index < 65535)
            smp_index++;
        if (!last)
            return 1'b0;

        res.count = n_cross[COUNT_W-1:0];
        if (rate_hz == 0) begin
            res.status = STATUS_RATE0;
        end else if (n_cross < 2) begin
            res.status = STATUS_FEW;
        end else begin
            res.status = STATUS_OK;
            diff    = latest_time > first_time ? 64'(latest_time - first_time) : 64'd0;
            periods = 64'(n_cross) - 64'd1;
            res.per = 32'(diff / periods);
            ns      = (diff * 64'd1_000_000_000) / (64'd256 * periods * 64'(rate_hz));
            res.ns  = ns > 64'(NS_MAX) ? NS_MAX : ns[NS_W-1:0];
            // frequency over the capped crossings only
            cdiff = cap_time > first_time ? 64'(cap_time - first_time) : 64'd0;
            q     = 64'(rate_hz) * (64'(n_cap) - 64'd1);
            if (cdiff == 0) begin
                res.freq = FREQ_MAX;
            end else begin
                hi  = q / cdiff;
                rem = q % cdiff;
                if (hi >= 64'd4096) begin
                    res.freq = FREQ_MAX;
                end else begin
                    freq     = (hi << 32) + ((rem << 32) / cdiff);
                    res.freq = freq > 64'(FREQ_MAX) ? FREQ_MAX : freq[FREQ_W-1:0];
                end
            end
        end

        // drop the block state ready for the next block
        prev_smp    = '0;
        have_prev   = 1'b0;
        smp_index   = '0;
        first_time  = '0;
        latest_time = '0;
        n_cross     = '0;
        cap_time    = '0;
        n_cap       = '0;
        return 1'b1;
    endfunction

    function automatic t_result make_result(input t_status st, input int count,
                                            input bit [PER_W-1:0] per,
                                            input bit [NS_W-1:0] ns,
                                            input bit [FREQ_W-1:0] freq);
        t_result r;
        r.status = st;
        r.count  = COUNT_W'(count);
        r.per    = per;
        r.ns     = ns;
        r.freq   = freq;
        return r;
    endfunction

    function automatic void add_row(input t_row_kind kind, input int value,
                                    input bit last = 1'b0, input bit typed = 1'b0,
                                    input t_result res = '0);
        t_stim_row row;
        row.kind  = kind;
        row.value = value;
        row.last  = last;
        row.typed = typed;
        row.res   = res;
        stim_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] result %0d: %s got %0d expected %0d",
                 $time, results_seen, what, got, want);
        mismatches++;
    endtask

    // Offer one sample in bursts with random gaps; predict once the request is taken
    task automatic send_sample(input logic signed [15:0] smp, input bit last,
                               input bit typed = 1'b0, input t_result typed_res = '0);
        int      gap;
        t_result res;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = $urandom_range(1, 40);
            repeat (gap) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= last;
        forever begin
            @(posedge clk);
            if (o_s_tready)
                break;
        end
        burst_left--;
        if (fold_sample(smp, last, res))
            results_due.push_back(typed ? typed_res : res);
    endtask

    // Write the sample rate once the unit has gone quiet
    task automatic write_rate(input logic [RATE_W-1:0] rate);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= rate;
        forever begin
            @(posedge clk);
            if (o_cfg_ready)
                break;
        end
        rate_hz = rate;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold the result side ready or stalled in runs of random length
    always @(negedge clk) begin
        if (ready_run == 0) begin
            case ($urandom_range(0, 5))
                0: begin
                    m_tready  <= 1'b0;
                    ready_run = $urandom_range(1, 20);
                end
                1: begin
                    m_tready  <= 1'b1;
                    ready_run = 200;
                end
                default: begin
                    m_tready  <= 1'($urandom_range(0, 1));
                    ready_run = $urandom_range(1, 6);
                end
            endcase
        end else begin
            ready_run = ready_run - 1;
        end
    end

    // Check each result taken against the oldest one due
    always @(posedge clk) begin : check_results
        t_result got;
        t_result want;
        if (rst_n && o_m_tvalid && m_tready) begin
            got = o_m_tdata[RESULT_W-1:0];
            results_seen++;
            if (results_due.size() == 0) begin
                report_mismatch("result with none due, count", 64'(got.count), 64'd0);
            end else begin
                want = results_due.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.count !== want.count)
                    report_mismatch("crossing_count", 64'(got.count), 64'(want.count));
                if (got.per !== want.per)
                    report_mismatch("period_samples_q16", 64'(got.per), 64'(want.per));
                if (got.ns !== want.ns)
                    report_mismatch("period_ns_q8", 64'(got.ns), 64'(want.ns));
                if (got.freq !== want.freq)
                    report_mismatch("frequency_hz_q16", 64'(got.freq), 64'(want.freq));
            end
            if (o_m_tdata[OUT_TDATA_W-1:RESULT_W] !== '0)
                report_mismatch("padding", 64'(o_m_tdata[OUT_TDATA_W-1:RESULT_W]), 64'd0);
        end
    end

    // End the run when no request has moved for too long
    always @(posedge clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("** zero_cross_period_freq_unit: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int              blk_len;
        int              per_len;
        int              amp;
        int              phase_items;
        bit              big;
        bit              noisy;
        logic [RATE_W-1:0] rate;
        logic signed [15:0] smp;

        // Directed rows; typed results where they follow at once
        add_row(ROW_SAMPLE, 32767, 1, 1, make_result(STATUS_FEW, 0, 0, 0, 0));
        add_row(ROW_SAMPLE, -32768);
        add_row(ROW_SAMPLE, 32767);
        add_row(ROW_SAMPLE, 0);
        add_row(ROW_SAMPLE, 1, 1);
        add_row(ROW_SAMPLE, -5);
        add_row(ROW_SAMPLE, 5, 1, 1, make_result(STATUS_FEW, 1, 0, 0, 0));
        add_row(ROW_SAMPLE, 0);
        add_row(ROW_SAMPLE, 0);
        add_row(ROW_SAMPLE, -1);
        add_row(ROW_SAMPLE, 1);
        add_row(ROW_SAMPLE, 1, 1, 1, make_result(STATUS_FEW, 1, 0, 0, 0));
        add_row(ROW_RATE, 0);
        add_row(ROW_SAMPLE, -1);
        add_row(ROW_SAMPLE, 1);
        add_row(ROW_SAMPLE, -1);
        add_row(ROW_SAMPLE, 1, 1, 1, make_result(STATUS_RATE0, 2, 0, 0, 0));
        add_row(ROW_SAMPLE, -32768, 1, 1, make_result(STATUS_RATE0, 0, 0, 0, 0));
        add_row(ROW_RATE, 28'hFFF_FFFF);
        add_row(ROW_SAMPLE, -32768);
        add_row(ROW_SAMPLE, 32767);
        add_row(ROW_SAMPLE, -32768);
        add_row(ROW_SAMPLE, 32767, 1);
        add_row(ROW_RATE, 1);
        add_row(ROW_SAMPLE, -1);
        add_row(ROW_SAMPLE, 1);
        add_row(ROW_SAMPLE, -1);
        add_row(ROW_SAMPLE, 1, 1);
        add_row(ROW_RATE, 200_000_000);
        add_row(ROW_SAMPLE, 0);
        add_row(ROW_SAMPLE, 16384);
        add_row(ROW_SAMPLE, -16384);
        add_row(ROW_SAMPLE, 16384, 1);

        // Hold reset, then release on a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_RATE)
                write_rate(stim_rows[i].value[RATE_W-1:0]);
            else
                send_sample(16'(stim_rows[i].value), stim_rows[i].last,
                            stim_rows[i].typed, stim_rows[i].res);
        end

        // Random phases, each under its own sample rate; one phase opens with a
        // block of more than the stored number of crossings
        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 7))
                0:       rate = '0;
                1:       rate = RATE_W'($urandom_range(1, 1000));
                2:       rate = '1;
                3:       rate = RATE_RESET;
                default: rate = RATE_W'($urandom_range(0, 200_000_000));
            endcase
            write_rate(rate);
            phase_items = 0;
            big = (ph == 2);
            while (phase_items < 70) begin
                // mostly oscillations with random shape, some plain noise
                if (big)
                    blk_len = $urandom_range(260, 300);
                else if ($urandom_range(0, 4) == 0)
                    blk_len = $urandom_range(1, 3);
                else
                    blk_len = $urandom_range(4, 30);
                noisy   = !big && ($urandom_range(0, 3) == 0);
                per_len = big ? 2 : $urandom_range(2, 12);
                amp     = $urandom_range(1, 32767);
                for (int k = 0; k < blk_len; k++) begin
                    if (noisy)
                        smp = 16'($urandom);
                    else if ((k % per_len) < per_len / 2)
                        smp = 16'(-$urandom_range(0, amp));
                    else
                        smp = 16'($urandom_range(1, amp));
                    send_sample(smp, k == blk_len - 1);
                end
                phase_items += blk_len;
                big = 1'b0;
            end
        end

        // Drain outstanding results, then allow for stray output
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** zero_cross_period_freq_unit: PASSED **");
        else
            $display("** zero_cross_period_freq_unit: FAILED **");
        $finish;
    end

endmodule
